// ===== rtl/plcm_pkg.sv =====
package plcm_pkg;

    localparam int CH_W          = 17;
    localparam int FRAC_W        = 16;
    localparam int NUM_CH        = 3;
    localparam int BYTE_W        = 8;
    localparam int CNT_W         = 5;
    localparam int SIDX_W        = 4;
    localparam int PIPE_DEPTH    = 6;
    localparam int MAX_STOPS_DEF = 16;

    localparam logic [CH_W-1:0]   ONE_Q16        = 17'h10000;
    localparam logic [CNT_W-1:0]  STOP_COUNT_RST = 5'd2;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE   = 8'hFF;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef logic [CH_W-1:0] ch_t;

    // Channel 0 is red, 1 green, 2 blue.
    typedef ch_t [NUM_CH-1:0] rgb_t;

    // Per-stage load enables; wr fires when a load item moves into stage 3.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic wr;
    } pipe_en_t;

endpackage

// ===== rtl/plcm_ctrl.sv =====
module plcm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_kind,
    input  logic               m_tready,
    output logic               s_tready,
    output logic               m_tvalid,
    output plcm_pkg::pipe_en_t en
);
    import plcm_pkg::*;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] rdy;
    logic                  kind1_reg;
    logic                  kind2_reg;
    logic                  load2;

    assign load2 = valid_reg[1] && (kind2_reg == CMD_LOAD);

    // A stage takes a new item when it is empty or its content moves on.
    always_comb begin
        rdy[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_tready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_comb begin
        valid_next[0] = s_tvalid;
        valid_next[1] = valid_reg[0];
        // Drop load items once they have written the table.
        valid_next[2] = valid_reg[1] && (kind2_reg == CMD_SAMPLE);
        for (int k = 3; k < PIPE_DEPTH; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            kind1_reg <= s_kind;
        end
        if (rdy[1]) begin
            kind2_reg <= kind1_reg;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[PIPE_DEPTH-1];

    assign en.s1 = rdy[0];
    assign en.s2 = rdy[1];
    assign en.s3 = rdy[2];
    assign en.s4 = rdy[3];
    assign en.s5 = rdy[4];
    assign en.s6 = rdy[5];
    assign en.wr = rdy[2] && load2;

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&valid_reg))
        else $error("input blocked while pipeline has a bubble");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (rdy[2] && load2) |=> !valid_reg[2])
        else $error("load item reached the interpolation stages");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted item lost at stage 1");

    a_hold_stage3: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[2] && !rdy[3]) |=> valid_reg[2])
        else $error("stalled stage 3 item dropped");

endmodule

// ===== rtl/plcm_addr.sv =====
module plcm_addr #(
    parameter int MAX_STOPS = plcm_pkg::MAX_STOPS_DEF
) (
    input  logic                          aclk,
    input  plcm_pkg::pipe_en_t            en,
    input  logic [plcm_pkg::CNT_W-1:0]    stop_count,
    input  logic [plcm_pkg::CH_W-1:0]     position,
    output logic [$clog2(MAX_STOPS)-1:0]  rd_addr0,
    output logic [$clog2(MAX_STOPS)-1:0]  rd_addr1,
    output logic [plcm_pkg::CH_W-1:0]     frac
);
    import plcm_pkg::*;

    localparam int ADDR_W = $clog2(MAX_STOPS);
    localparam int SCL_W  = CH_W + ADDR_W;

    logic [CH_W-1:0]   pos1_reg;
    logic [SCL_W-1:0]  scaled2_reg;
    logic [ADDR_W-1:0] nm1;
    logic [ADDR_W-1:0] lim;
    logic [ADDR_W:0]   idx_raw;
    logic [ADDR_W-1:0] idx;
    logic [SCL_W-1:0]  frac_wide;

    // Stop count minus one, with zero acting as one and the top clamped.
    always_comb begin
        if (stop_count == '0) begin
            nm1 = '0;
        end else if (32'(stop_count) > MAX_STOPS) begin
            nm1 = ADDR_W'(MAX_STOPS - 1);
        end else begin
            nm1 = ADDR_W'(stop_count - 5'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            pos1_reg <= (position > ONE_Q16) ? ONE_Q16 : position;
        end
        if (en.s2) begin
            scaled2_reg <= SCL_W'(pos1_reg) * SCL_W'(nm1);
        end
    end

    // With a single stop the scaled value is zero, so index and fraction are zero.
    always_comb begin
        lim       = nm1 - 1'b1;
        idx_raw   = scaled2_reg[SCL_W-1:FRAC_W];
        idx       = (idx_raw > {1'b0, lim}) ? lim : idx_raw[ADDR_W-1:0];
        frac_wide = scaled2_reg - (SCL_W'(idx) << FRAC_W);
    end

    // Keep a single stop on stop 0 for both reads.
    assign rd_addr0 = idx;
    assign rd_addr1 = (nm1 == '0) ? idx : idx + 1'b1;
    assign frac     = frac_wide[CH_W-1:0];

endmodule

// ===== rtl/plcm_table.sv =====
module plcm_table #(
    parameter int MAX_STOPS = plcm_pkg::MAX_STOPS_DEF
) (
    input  logic                          aclk,
    input  plcm_pkg::pipe_en_t            en,
    input  logic [plcm_pkg::SIDX_W-1:0]   wr_index,
    input  plcm_pkg::rgb_t                wr_color,
    input  logic [$clog2(MAX_STOPS)-1:0]  rd_addr0,
    input  logic [$clog2(MAX_STOPS)-1:0]  rd_addr1,
    output plcm_pkg::rgb_t                rd_color0,
    output plcm_pkg::rgb_t                rd_color1
);
    import plcm_pkg::*;

    localparam int ADDR_W = $clog2(MAX_STOPS);

    rgb_t              mem [MAX_STOPS];
    logic [SIDX_W-1:0] idx1_reg;
    logic [SIDX_W-1:0] idx2_reg;
    rgb_t              color1_reg;
    rgb_t              color2_reg;
    rgb_t              rd0_reg;
    rgb_t              rd1_reg;

    // Carry load data alongside the item so the write lands in item order.
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            idx1_reg   <= wr_index;
            color1_reg <= wr_color;
        end
        if (en.s2) begin
            idx2_reg   <= idx1_reg;
            color2_reg <= color1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.wr && (32'(idx2_reg) < MAX_STOPS)) begin
            mem[ADDR_W'(idx2_reg)] <= color2_reg;
        end
        if (en.s3) begin
            rd0_reg <= mem[rd_addr0];
            rd1_reg <= mem[rd_addr1];
        end
    end

    assign rd_color0 = rd0_reg;
    assign rd_color1 = rd1_reg;

endmodule

// ===== rtl/plcm_lerp.sv =====
module plcm_lerp (
    input  logic                     aclk,
    input  plcm_pkg::pipe_en_t       en,
    input  logic [plcm_pkg::CH_W-1:0] frac,
    input  plcm_pkg::rgb_t           color0,
    input  plcm_pkg::rgb_t           color1,
    output plcm_pkg::rgb_t           color_out,
    output logic [31:0]              packed_rgba
);
    import plcm_pkg::*;

    localparam int DIFF_W = CH_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = CH_W + 2;
    localparam int MUL_W  = CH_W + BYTE_W;

    logic [CH_W-1:0]          frac3_reg;
    logic signed [PROD_W-1:0] prod4_reg [NUM_CH];
    ch_t                      c0_4_reg [NUM_CH];
    rgb_t                     rgb5_reg;
    rgb_t                     rgb6_reg;
    logic [31:0]              rgba6_reg;

    logic signed [DIFF_W-1:0] diff [NUM_CH];
    logic signed [PROD_W-1:0] prod [NUM_CH];
    logic signed [PROD_W-1:0] shifted [NUM_CH];
    logic signed [SUM_W-1:0]  sum [NUM_CH];
    rgb_t                     rgb_clamped;
    logic [MUL_W-1:0]         times255 [NUM_CH];
    logic [BYTE_W:0]          byte_raw [NUM_CH];
    logic [BYTE_W-1:0]        byte_sat [NUM_CH];

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            diff[k] = $signed({1'b0, color1[k]}) - $signed({1'b0, color0[k]});
            prod[k] = $signed({1'b0, frac3_reg}) * diff[k];
        end
    end

    // Arithmetic shift floors the product; clamp anything below zero.
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            shifted[k]     = prod4_reg[k] >>> FRAC_W;
            sum[k]         = $signed({2'b00, c0_4_reg[k]}) + $signed(shifted[k][SUM_W-1:0]);
            rgb_clamped[k] = sum[k][SUM_W-1] ? '0 : sum[k][CH_W-1:0];
        end
    end

    // v * 255 as a shift and subtract, then saturate to one byte.
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            times255[k] = {rgb5_reg[k], {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, rgb5_reg[k]};
            byte_raw[k] = times255[k][MUL_W-1:FRAC_W];
            byte_sat[k] = byte_raw[k][BYTE_W] ? {BYTE_W{1'b1}} : byte_raw[k][BYTE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            frac3_reg <= frac;
        end
        if (en.s4) begin
            for (int k = 0; k < NUM_CH; k++) begin
                prod4_reg[k] <= prod[k];
                c0_4_reg[k]  <= color0[k];
            end
        end
        if (en.s5) begin
            rgb5_reg <= rgb_clamped;
        end
        if (en.s6) begin
            rgb6_reg  <= rgb5_reg;
            rgba6_reg <= {ALPHA_OPAQUE, byte_sat[2], byte_sat[1], byte_sat[0]};
        end
    end

    assign color_out   = rgb6_reg;
    assign packed_rgba = rgba6_reg;

endmodule

// ===== rtl/piecewise_linear_color_map_top.sv =====
// Piecewise-linear color map. Load items (tuser = 0) write one color stop of
// the table; sample items (tuser = 1) return the color at a Q1.16 position,
// interpolated between the two neighboring stops, as three Q1.16 channels and
// as a packed 8-bit RGBA word with opaque alpha. The pipeline takes one item
// every clock unless m_tready stalls it, and has six register stages; each
// sample item returns one result on m_tvalid, and a load item produces nothing.
// The stop table has two read ports and is read in stage 3, where load items
// also write, so stops loaded earlier are always seen by later samples.
// Backpressure on m_tready stalls stages from the output back, filling bubbles
// first. Write stop_count only while no sample is in flight; every stop the
// count covers must be loaded before it is sampled.
module piecewise_linear_color_map_top #(
    parameter int MAX_STOPS = plcm_pkg::MAX_STOPS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // cfg_data: stop_count
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [plcm_pkg::CNT_W-1:0]  cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata: stop_index[3:0], red_in[20:4], green_in[37:21], blue_in[54:38],
    //          position[71:55]
    input  logic [71:0]                 s_tdata,
    // s_tuser: cmd
    input  logic                        s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata: red[16:0], green[33:17], blue[50:34], packed_rgba[82:51], zeros
    output logic [87:0]                 m_tdata
);
    import plcm_pkg::*;

    localparam int ADDR_W = $clog2(MAX_STOPS);

    logic [CNT_W-1:0]  stop_count_reg;
    pipe_en_t          en;
    rgb_t              wr_color;
    logic [ADDR_W-1:0] rd_addr0;
    logic [ADDR_W-1:0] rd_addr1;
    logic [CH_W-1:0]   frac;
    rgb_t              color0;
    rgb_t              color1;
    rgb_t              color_out;
    logic [31:0]       packed_rgba;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_count_reg <= STOP_COUNT_RST;
        end else if (cfg_valid) begin
            stop_count_reg <= cfg_data;
        end
    end

    assign wr_color[0] = s_tdata[20:4];
    assign wr_color[1] = s_tdata[37:21];
    assign wr_color[2] = s_tdata[54:38];

    plcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .en       (en)
    );

    plcm_addr #(.MAX_STOPS(MAX_STOPS)) u_addr (
        .aclk       (aclk),
        .en         (en),
        .stop_count (stop_count_reg),
        .position   (s_tdata[71:55]),
        .rd_addr0   (rd_addr0),
        .rd_addr1   (rd_addr1),
        .frac       (frac)
    );

    plcm_table #(.MAX_STOPS(MAX_STOPS)) u_table (
        .aclk      (aclk),
        .en        (en),
        .wr_index  (s_tdata[3:0]),
        .wr_color  (wr_color),
        .rd_addr0  (rd_addr0),
        .rd_addr1  (rd_addr1),
        .rd_color0 (color0),
        .rd_color1 (color1)
    );

    plcm_lerp u_lerp (
        .aclk        (aclk),
        .en          (en),
        .frac        (frac),
        .color0      (color0),
        .color1      (color1),
        .color_out   (color_out),
        .packed_rgba (packed_rgba)
    );

    assign m_tdata = {5'b0, packed_rgba, color_out[2], color_out[1], color_out[0]};

endmodule
